@@ hw/rtl/swerm_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the sliding window event rate meter
// no dependencies; used by swerm_ctrl, swerm_dpath and the core top level

package swerm_pkg;

   // widths fixed by the register and result fields
   localparam int REG_BITS       = 24;
   localparam int RATE_BITS      = 24;
   localparam int SCALE_BITS     = 27;
   localparam int CSR_INDEX_BITS = 1;

   // rate scale: hundredths per second from microsecond spans
   localparam logic [SCALE_BITS-1:0] RATE_SCALE = 27'd100000000;
   localparam logic [RATE_BITS-1:0]  RATE_MAX   = 24'hFFFFFF;
   localparam int                    MIN_STAMPS = 3;

   // configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_LENGTH   = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RECALC_INTERVAL = 1'd1;

   // register reset values
   localparam logic [REG_BITS-1:0] WINDOW_LENGTH_RESET   = 24'd1000000;
   localparam logic [REG_BITS-1:0] RECALC_INTERVAL_RESET = 24'd500000;

   // controller to datapath commands
   typedef struct packed {
      logic load;            // take the new stamp and append it
      logic pop;             // drop the oldest held stamp
      logic recalc_trivial;  // recalculation with too few stamps or zero span
      logic div_start;       // load divider and note recalculation time
      logic div_step;        // one restoring division step
      logic div_done;        // saturate quotient into held rate
      logic out_load;        // capture result into output register
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic pop_needed;      // oldest held stamp is older than the window
      logic recalc_due;      // recalculation interval has elapsed
      logic rate_trivial;    // fewer than three stamps or zero span
   } status_type;

endpackage

@@ hw/rtl/swerm_ctrl.sv @@
`timescale 1ns / 1ps
// controller state machine for the event rate meter
// depends on swerm_pkg; drives swerm_dpath through cmd_type and reads status_type

module swerm_ctrl #(
   parameter int DIV_STEPS = 36
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  swerm_pkg::status_type status,
   output swerm_pkg::cmd_type    cmd
);

   localparam int STEP_BITS = $clog2(DIV_STEPS);
   localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(DIV_STEPS - 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_READ   = 3'd1;
   localparam logic [2:0] ST_CHECK  = 3'd2;
   localparam logic [2:0] ST_EVAL   = 3'd3;
   localparam logic [2:0] ST_DIV    = 3'd4;
   localparam logic [2:0] ST_SAT    = 3'd5;
   localparam logic [2:0] ST_FINISH = 3'd6;

   logic [2:0]           state_ff, state_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.pop_needed) begin
               cmd.pop  = 1'b1;
               state_in = ST_READ;
            end else begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (!status.recalc_due) begin
               state_in = ST_FINISH;
            end else if (status.rate_trivial) begin
               cmd.recalc_trivial = 1'b1;
               state_in           = ST_FINISH;
            end else begin
               cmd.div_start = 1'b1;
               step_in       = '0;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_SAT;
            end
         end
         ST_SAT: begin
            cmd.div_done = 1'b1;
            state_in     = ST_FINISH;
         end
         ST_FINISH: begin
            // wait for the output register to be free
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

@@ hw/rtl/swerm_dpath.sv @@
`timescale 1ns / 1ps
// datapath of the event rate meter: stamp ring memory, pointers, divider, held rate
// depends on swerm_pkg; commanded by swerm_ctrl

module swerm_dpath #(
   parameter int WINDOW_DEPTH = 256,
   parameter int TIME_BITS    = 48
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [TIME_BITS-1:0]                  event_time,
   input  logic                                  csr_wr_en,
   input  logic [swerm_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [swerm_pkg::REG_BITS-1:0]        csr_wdata,
   input  swerm_pkg::cmd_type                    cmd,
   output swerm_pkg::status_type                 status,
   output logic [swerm_pkg::RATE_BITS-1:0]       out_rate,
   output logic                                  out_valid,
   output logic                                  out_recalc,
   output logic                                  out_overflow
);

   localparam int PTR_BITS = $clog2(WINDOW_DEPTH);
   localparam int CNT_BITS = $clog2(WINDOW_DEPTH + 1);
   localparam int NUM_BITS = CNT_BITS + swerm_pkg::SCALE_BITS;
   localparam int RB       = swerm_pkg::RATE_BITS;
   localparam logic [CNT_BITS-1:0] DEPTH_CNT = CNT_BITS'(WINDOW_DEPTH);
   localparam logic [PTR_BITS-1:0] LAST_SLOT = PTR_BITS'(WINDOW_DEPTH - 1);
   localparam logic [PTR_BITS:0]   DEPTH_SUM = (PTR_BITS + 1)'(WINDOW_DEPTH);

   // configuration
   logic [swerm_pkg::REG_BITS-1:0] window_len_ff, window_len_in;
   logic [swerm_pkg::REG_BITS-1:0] recalc_int_ff, recalc_int_in;

   // control state
   logic [PTR_BITS-1:0]  ptr_ff, ptr_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [TIME_BITS-1:0] last_recalc_ff, last_recalc_in;
   logic [RB-1:0]        held_rate_ff, held_rate_in;
   logic                 held_valid_ff, held_valid_in;

   // payload
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic                 overflow_ff, overflow_in;
   logic                 recalc_ff, recalc_in;
   logic [NUM_BITS-1:0]  quo_ff, quo_in;
   logic [TIME_BITS-1:0] rem_ff, rem_in;
   logic [TIME_BITS-1:0] span_ff, span_in;
   logic [TIME_BITS-1:0] rd_data_ff;
   logic [RB-1:0]        out_rate_ff, out_rate_in;
   logic                 out_valid_ff, out_valid_in;
   logic                 out_recalc_ff, out_recalc_in;
   logic                 out_overflow_ff, out_overflow_in;

   logic [TIME_BITS-1:0] stamp_mem [WINDOW_DEPTH];

   // ring arithmetic
   logic [PTR_BITS-1:0]  ptr_inc;
   logic                 store_full;
   logic [PTR_BITS-1:0]  ptr_adj;
   logic [CNT_BITS-1:0]  cnt_adj;
   logic [PTR_BITS:0]    slot_sum;
   logic [PTR_BITS:0]    slot_wrap;
   logic [PTR_BITS-1:0]  wr_addr;

   // time and divider arithmetic
   logic [TIME_BITS-1:0] age;
   logic [TIME_BITS-1:0] since_recalc;
   logic [CNT_BITS-1:0]  count_minus1;
   logic [NUM_BITS-1:0]  product;
   logic [TIME_BITS:0]   rem_shift;
   logic [TIME_BITS:0]   rem_sub;
   logic                 rem_ge;
   logic [RB-1:0]        sat_rate;

   assign ptr_inc    = (ptr_ff == LAST_SLOT) ? '0 : ptr_ff + 1'b1;
   assign store_full = (count_ff == DEPTH_CNT);
   assign ptr_adj    = store_full ? ptr_inc : ptr_ff;
   assign cnt_adj    = store_full ? DEPTH_CNT - 1'b1 : count_ff;
   assign slot_sum   = {1'b0, ptr_adj} + {1'b0, cnt_adj[PTR_BITS-1:0]};
   assign slot_wrap  = slot_sum - DEPTH_SUM;
   assign wr_addr    = (slot_sum >= DEPTH_SUM) ? slot_wrap[PTR_BITS-1:0]
                                               : slot_sum[PTR_BITS-1:0];

   // rd_data_ff holds the oldest stamp from the cycle after ptr moved
   assign age          = now_ff - rd_data_ff;
   assign since_recalc = now_ff - last_recalc_ff;
   assign count_minus1 = count_ff - 1'b1;
   assign product      = NUM_BITS'(count_minus1) * NUM_BITS'(swerm_pkg::RATE_SCALE);

   assign rem_shift = {rem_ff, quo_ff[NUM_BITS-1]};
   assign rem_sub   = rem_shift - {1'b0, span_ff};
   assign rem_ge    = (rem_shift >= {1'b0, span_ff});
   assign sat_rate  = (|quo_ff[NUM_BITS-1:RB]) ? swerm_pkg::RATE_MAX : quo_ff[RB-1:0];

   assign status.pop_needed   = (age > TIME_BITS'(window_len_ff));
   assign status.recalc_due   = (since_recalc >= TIME_BITS'(recalc_int_ff));
   assign status.rate_trivial = (count_ff < CNT_BITS'(swerm_pkg::MIN_STAMPS))
                                || (age == '0);

   always_comb begin
      window_len_in   = window_len_ff;
      recalc_int_in   = recalc_int_ff;
      ptr_in          = ptr_ff;
      count_in        = count_ff;
      last_recalc_in  = last_recalc_ff;
      held_rate_in    = held_rate_ff;
      held_valid_in   = held_valid_ff;
      now_in          = now_ff;
      overflow_in     = overflow_ff;
      recalc_in       = recalc_ff;
      quo_in          = quo_ff;
      rem_in          = rem_ff;
      span_in         = span_ff;
      out_rate_in     = out_rate_ff;
      out_valid_in    = out_valid_ff;
      out_recalc_in   = out_recalc_ff;
      out_overflow_in = out_overflow_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            swerm_pkg::CSR_WINDOW_LENGTH:   window_len_in = csr_wdata;
            swerm_pkg::CSR_RECALC_INTERVAL: recalc_int_in = csr_wdata;
         endcase
      end

      priority if (cmd.load) begin
         now_in      = event_time;
         ptr_in      = ptr_adj;
         count_in    = cnt_adj + 1'b1;
         overflow_in = store_full;
         recalc_in   = 1'b0;
      end else if (cmd.pop) begin
         ptr_in   = ptr_inc;
         count_in = count_ff - 1'b1;
      end else if (cmd.recalc_trivial) begin
         last_recalc_in = now_ff;
         held_rate_in   = '0;
         held_valid_in  = 1'b0;
         recalc_in      = 1'b1;
      end else if (cmd.div_start) begin
         last_recalc_in = now_ff;
         recalc_in      = 1'b1;
         quo_in         = product;
         rem_in         = '0;
         span_in        = age;
      end else if (cmd.div_step) begin
         quo_in = {quo_ff[NUM_BITS-2:0], rem_ge};
         rem_in = rem_ge ? rem_sub[TIME_BITS-1:0] : rem_shift[TIME_BITS-1:0];
      end else if (cmd.div_done) begin
         held_rate_in  = sat_rate;
         held_valid_in = 1'b1;
      end else if (cmd.out_load) begin
         out_rate_in     = held_rate_ff;
         out_valid_in    = held_valid_ff;
         out_recalc_in   = recalc_ff;
         out_overflow_in = overflow_ff;
      end else begin
         now_in = now_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff  <= swerm_pkg::WINDOW_LENGTH_RESET;
         recalc_int_ff  <= swerm_pkg::RECALC_INTERVAL_RESET;
         ptr_ff         <= '0;
         count_ff       <= '0;
         last_recalc_ff <= '0;
         held_rate_ff   <= '0;
         held_valid_ff  <= 1'b0;
      end else begin
         window_len_ff  <= window_len_in;
         recalc_int_ff  <= recalc_int_in;
         ptr_ff         <= ptr_in;
         count_ff       <= count_in;
         last_recalc_ff <= last_recalc_in;
         held_rate_ff   <= held_rate_in;
         held_valid_ff  <= held_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff          <= now_in;
      overflow_ff     <= overflow_in;
      recalc_ff       <= recalc_in;
      quo_ff          <= quo_in;
      rem_ff          <= rem_in;
      span_ff         <= span_in;
      out_rate_ff     <= out_rate_in;
      out_valid_ff    <= out_valid_in;
      out_recalc_ff   <= out_recalc_in;
      out_overflow_ff <= out_overflow_in;
   end

   // stamp ring: one write port, one registered read port at the oldest slot
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         stamp_mem[wr_addr] <= event_time;
      end
      rd_data_ff <= stamp_mem[ptr_ff];
   end

   assign out_rate     = out_rate_ff;
   assign out_valid    = out_valid_ff;
   assign out_recalc   = out_recalc_ff;
   assign out_overflow = out_overflow_ff;

endmodule

@@ hw/rtl/sliding_window_event_rate_meter_core.sv @@
`timescale 1ns / 1ps
// top level of the sliding window event rate meter
// depends on swerm_pkg, swerm_ctrl and swerm_dpath
//
//   channel | direction | transfer contents
//   --------+-----------+----------------------------------------------------
//   req_    | in        | one event timestamp in microseconds
//   rsp_    | out       | held rate, its valid flag, recalc and overflow flags
//   csr_    | in        | write of window length or recalculation interval
//
// sequence: accept; one ring read and check per stamp dropped, plus a final one;
//   recalculation decision; if the divider runs, DIV_STEPS bit-serial restoring steps
//   (clog2(WINDOW_DEPTH+1) + 27, i.e. 36 at the default depth) and saturation; deliver
// reset: synchronous, clears pointers, count, held rate and registers; the
//   stamp memory is not cleared, only written slots are ever read
// stalls: a finished result sits in the output register; a new event is taken
//   meanwhile and waits in its last state only if the old result is still held

module sliding_window_event_rate_meter_core #(
   parameter int WINDOW_DEPTH = 256,
   parameter int TIME_BITS    = 48
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((TIME_BITS+7)/8)*8-1:0]       req_tdata,  // event_time_us
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [swerm_pkg::RATE_BITS-1:0]      rsp_tdata,  // rate_hundredths
   output logic [2:0]                           rsp_tuser,  // rate_valid, recalculated,
                                                            // window_overflow
   input  logic                                 csr_wr_en,
   input  logic [swerm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [swerm_pkg::REG_BITS-1:0]       csr_wdata
);

   localparam int CNT_BITS  = $clog2(WINDOW_DEPTH + 1);
   localparam int DIV_STEPS = CNT_BITS + swerm_pkg::SCALE_BITS;

   swerm_pkg::cmd_type    cmd;
   swerm_pkg::status_type status;

   logic [swerm_pkg::RATE_BITS-1:0] out_rate;
   logic                            out_valid;
   logic                            out_recalc;
   logic                            out_overflow;

   // sequencing: accept, ring check loop, recalculation decision, divide, deliver
   swerm_ctrl #(
      .DIV_STEPS (DIV_STEPS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // stamp ring, ageing compares, divider and output register
   swerm_dpath #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .TIME_BITS    (TIME_BITS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .event_time   (req_tdata[TIME_BITS-1:0]),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .status       (status),
      .out_rate     (out_rate),
      .out_valid    (out_valid),
      .out_recalc   (out_recalc),
      .out_overflow (out_overflow)
   );

   assign rsp_tdata = out_rate;
   assign rsp_tuser = {out_overflow, out_recalc, out_valid};

   // one event at a time: no second transfer straight after an accepted one
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken while previous event still in work");

   // the divider always runs its first step right after being loaded
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> cmd.div_step)
      else $error("divider loaded but not stepped");

   // a result is never written over one that is still waiting
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_tvalid || rsp_tready))
      else $error("pending result overwritten");

   // a captured result is presented in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_tvalid)
      else $error("captured result not presented");

endmodule
